// ===== rtl/qdf_pkg.sv =====
// Package for the quadrature demodulator: defaults, register indexes, request kinds,
// controller/datapath command and status types, sine quarter-wave table function.
// No dependencies.
`timescale 1ns / 1ps

package qdf_pkg;

    // Default sizes
    localparam int TAPS_DEF            = 64;
    localparam int SINE_TABLE_BITS_DEF = 10;

    // Configuration register map
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT  = 1'b1;

    // Request kinds carried on tuser
    localparam logic KIND_COEF   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Register reset values
    localparam logic [31:0] PHASE_STEP_RST = 32'd779132389;
    localparam logic [6:0]  TAP_COUNT_RST  = 7'd64;

    // Sine polynomial coefficients, Q2.30
    localparam logic [63:0] Q30_C1 = 64'd1686629713;
    localparam logic [63:0] Q30_C3 = 64'd693598667;
    localparam logic [63:0] Q30_C5 = 64'd85569310;
    localparam logic [63:0] Q30_C7 = 64'd5026994;
    localparam logic [63:0] Q30_C9 = 64'd172272;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIN,
        S_COS,
        S_PUSH,
        S_MAC,
        S_DRAIN1,
        S_DRAIN2,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic coef_wr;   // write one coefficient
        logic start;     // capture sample, look up negated sine, advance phase
        logic mix_q;     // quadrature product, look up cosine
        logic mix_i;     // in-phase product
        logic push;      // push products into the delay line, clear accumulator
        logic mac_step;  // issue one tap read
        logic out_load;  // load the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic taps_zero;
        logic tap_last;
        logic out_busy;
    } status_t;

    // Sine magnitude at a quarter-wave position, Q1.15, evaluated at elaboration
    function automatic logic [14:0] sine_mag(input int unsigned pos, input int unsigned bits);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] acc;
        logic [63:0] v;
        z   = 64'(pos) << (30 - (bits - 2));
        z2  = (z * z) >> 30;
        acc = Q30_C7 - ((z2 * Q30_C9) >> 30);
        acc = Q30_C5 - ((z2 * acc) >> 30);
        acc = Q30_C3 - ((z2 * acc) >> 30);
        acc = Q30_C1 - ((z2 * acc) >> 30);
        v   = (z * acc) >> 30;
        v   = (v + 64'd16384) >> 15;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[14:0];
    endfunction

endpackage

// ===== rtl/qdf_ctrl.sv =====
// Controller state machine for the quadrature demodulator.
// Sequences mixing, delay-line push, the tap MAC pass and result hand-off.
// Depends on qdf_pkg.
`timescale 1ns / 1ps

module qdf_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_kind,
    output logic             in_ready,
    output qdf_pkg::cmd_t    cmd,
    input  qdf_pkg::status_t status
);

    qdf_pkg::state_t state_reg;
    qdf_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qdf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            qdf_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_kind == qdf_pkg::KIND_SAMPLE)
                    begin
                        cmd.start  = 1'b1;
                        state_next = qdf_pkg::S_SIN;
                    end
                    else
                    begin
                        cmd.coef_wr = 1'b1;
                    end
                end
            end
            qdf_pkg::S_SIN:
            begin
                cmd.mix_q  = 1'b1;
                state_next = qdf_pkg::S_COS;
            end
            qdf_pkg::S_COS:
            begin
                cmd.mix_i  = 1'b1;
                state_next = qdf_pkg::S_PUSH;
            end
            qdf_pkg::S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = status.taps_zero ? qdf_pkg::S_DONE : qdf_pkg::S_MAC;
            end
            qdf_pkg::S_MAC:
            begin
                cmd.mac_step = 1'b1;
                if (status.tap_last)
                begin
                    state_next = qdf_pkg::S_DRAIN1;
                end
            end
            qdf_pkg::S_DRAIN1:
            begin
                state_next = qdf_pkg::S_DRAIN2;
            end
            qdf_pkg::S_DRAIN2:
            begin
                state_next = qdf_pkg::S_DONE;
            end
            qdf_pkg::S_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = qdf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = qdf_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/qdf_dp.sv =====
// Datapath for the quadrature demodulator: phase accumulator, sine ROM, mixer,
// circular delay memory, coefficient memory, dual MAC and output register.
// Depends on qdf_pkg.
`timescale 1ns / 1ps

module qdf_dp
#(
    parameter int TAPS            = qdf_pkg::TAPS_DEF,
    parameter int SINE_TABLE_BITS = qdf_pkg::SINE_TABLE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  qdf_pkg::cmd_t      cmd,
    output qdf_pkg::status_t   status,
    input  logic [31:0]        phase_step,
    input  logic [6:0]         tap_count,
    input  logic [5:0]         coef_index,
    input  logic signed [15:0] coef_value,
    input  logic signed [15:0] sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] in_phase,
    output logic signed [15:0] quadrature
);

    localparam int SB     = SINE_TABLE_BITS;
    localparam int QN     = 1 << (SB - 2);
    localparam int IDX_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int FILL_W = $clog2(TAPS + 1);
    localparam int CMP_W  = (FILL_W > 7) ? FILL_W : 7;
    localparam int ACC_W  = 32 + $clog2(TAPS + 1);

    // Quarter-wave sine ROM, positions 0..QN inclusive
    logic [14:0] qtab [QN+1];

    for (genvar g = 0; g < QN + 1; g++)
    begin : g_tab
        assign qtab[g] = qdf_pkg::sine_mag(g, SB);
    end

    logic [31:0]        phase_reg;
    logic [SB-1:0]      k_reg;
    logic signed [15:0] sample_reg;
    logic [14:0]        tab_reg;
    logic               tneg_reg;
    logic signed [32:0] mq_reg;
    logic signed [32:0] mi_reg;

    logic [IDX_W-1:0]   wptr_reg;
    logic [IDX_W-1:0]   wptr_next;
    logic [IDX_W-1:0]   rptr_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [IDX_W-1:0]   tap_idx_reg;

    logic [31:0]        dmem [TAPS];
    logic [15:0]        cmem [TAPS];
    logic [31:0]        dly_rd_reg;
    logic signed [15:0] coef_rd_reg;
    logic               rd_valid_reg;
    logic               rd_ok_reg;
    logic signed [31:0] prod_i_reg;
    logic signed [31:0] prod_q_reg;
    logic               prod_valid_reg;
    logic signed [ACC_W-1:0] acc_i_reg;
    logic signed [ACC_W-1:0] acc_q_reg;

    logic               out_valid_reg;
    logic signed [15:0] out_i_reg;
    logic signed [15:0] out_q_reg;

    // Table addresses for negated sine (current phase) and cosine (quarter ahead)
    logic [SB-1:0]      k_now;
    logic [SB-1:0]      k_cos;
    logic [SB-2:0]      pos_sin;
    logic [SB-2:0]      pos_cos;
    logic signed [16:0] trig;
    logic signed [32:0] mix_prod;
    logic [15:0]        mix_i_rnd;
    logic [15:0]        mix_q_rnd;
    logic [CMP_W-1:0]   used;
    logic [CMP_W-1:0]   cidx_ext;
    logic               cidx_ok;
    logic               age_ok;
    logic [15:0]        acc_i_rnd;
    logic [15:0]        acc_q_rnd;

    function automatic logic [SB-2:0] quarter_pos(input logic [SB-1:0] k);
        logic [SB-2:0] r;
        r = {1'b0, k[SB-3:0]};
        return k[SB-2] ? ((SB-1)'(QN) - r) : r;
    endfunction

    // Round a Q2.30 mixer product to Q1.15 with saturation
    function automatic logic [15:0] round_mix(input logic signed [32:0] p);
        logic signed [32:0] s;
        s = p + 33'sd16384;
        if ((&s[32:30]) || !(|s[32:30]))
        begin
            return s[30:15];
        end
        return s[32] ? 16'h8000 : 16'h7fff;
    endfunction

    // Double, round and saturate a filter sum to Q1.15
    function automatic logic [15:0] round_acc(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] s;
        s = a + ACC_W'(8192);
        if ((&s[ACC_W-1:29]) || !(|s[ACC_W-1:29]))
        begin
            return s[29:14];
        end
        return s[ACC_W-1] ? 16'h8000 : 16'h7fff;
    endfunction

    assign k_now     = phase_reg[31 -: SB];
    assign k_cos     = k_reg + SB'(QN);
    assign pos_sin   = quarter_pos(k_now);
    assign pos_cos   = quarter_pos(k_cos);
    assign trig      = tneg_reg ? -$signed({2'b00, tab_reg}) : $signed({2'b00, tab_reg});
    assign mix_prod  = sample_reg * trig;
    assign mix_i_rnd = round_mix(mi_reg);
    assign mix_q_rnd = round_mix(mq_reg);
    assign wptr_next = (wptr_reg == IDX_W'(TAPS - 1)) ? '0 : wptr_reg + 1'b1;
    assign used      = (CMP_W'(tap_count) > CMP_W'(TAPS)) ? CMP_W'(TAPS) : CMP_W'(tap_count);
    assign cidx_ext  = CMP_W'(coef_index);
    assign cidx_ok   = cidx_ext < CMP_W'(TAPS);
    assign age_ok    = FILL_W'(tap_idx_reg) < fill_reg;
    assign acc_i_rnd = round_acc(acc_i_reg);
    assign acc_q_rnd = round_acc(acc_q_reg);

    assign status.taps_zero = (tap_count == 7'd0);
    assign status.tap_last  = (CMP_W'(tap_idx_reg) == used - 1'b1);
    assign status.out_busy  = out_valid_reg && !out_ready;

    // Phase accumulator, delay-line pointers and tap counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            wptr_reg    <= '0;
            rptr_reg    <= '0;
            fill_reg    <= '0;
            tap_idx_reg <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                phase_reg <= phase_reg + phase_step;
            end
            if (cmd.push)
            begin
                wptr_reg    <= wptr_next;
                rptr_reg    <= wptr_next;
                tap_idx_reg <= '0;
                if (fill_reg != FILL_W'(TAPS))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            else if (cmd.mac_step)
            begin
                tap_idx_reg <= tap_idx_reg + 1'b1;
                rptr_reg    <= (rptr_reg == '0) ? IDX_W'(TAPS - 1) : rptr_reg - 1'b1;
            end
        end
    end

    // Sine ROM read and mixer
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            sample_reg <= sample;
            k_reg      <= k_now;
            tab_reg    <= qtab[pos_sin];
            tneg_reg   <= ~k_now[SB-1];
        end
        if (cmd.mix_q)
        begin
            mq_reg   <= mix_prod;
            tab_reg  <= qtab[pos_cos];
            tneg_reg <= k_cos[SB-1];
        end
        if (cmd.mix_i)
        begin
            mi_reg <= mix_prod;
        end
    end

    // Delay and coefficient memories
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            dmem[wptr_next] <= {mix_q_rnd, mix_i_rnd};
        end
        if (cmd.coef_wr && cidx_ok)
        begin
            cmem[cidx_ext[IDX_W-1:0]] <= coef_value;
        end
        dly_rd_reg  <= dmem[rptr_reg];
        coef_rd_reg <= cmem[tap_idx_reg];
    end

    // MAC pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            rd_ok_reg      <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= cmd.mac_step;
            rd_ok_reg      <= age_ok;
            prod_valid_reg <= rd_valid_reg && rd_ok_reg;
        end
    end

    // Products and accumulation
    always_ff @(posedge clk)
    begin
        prod_i_reg <= $signed(dly_rd_reg[15:0]) * coef_rd_reg;
        prod_q_reg <= $signed(dly_rd_reg[31:16]) * coef_rd_reg;
        if (cmd.push)
        begin
            acc_i_reg <= '0;
            acc_q_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_i_reg <= acc_i_reg + ACC_W'(prod_i_reg);
            acc_q_reg <= acc_q_reg + ACC_W'(prod_q_reg);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_i_reg <= acc_i_rnd;
            out_q_reg <= acc_q_rnd;
        end
    end

    assign out_valid  = out_valid_reg;
    assign in_phase   = out_i_reg;
    assign quadrature = out_q_reg;

`ifndef SYNTHESIS
    a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mac_step |-> (CMP_W'(tap_idx_reg) < used))
        else $error("tap read beyond taps in use");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(TAPS))
        else $error("delay fill count overran");

    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rd_valid_reg && !prod_valid_reg))
        else $error("result taken before MAC pipeline drained");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && !out_ready))
        else $error("output register overwritten while held");
`endif

endmodule

// ===== rtl/quadrature_demodulator_fir.sv =====
// Sample request: mixing, delay-line push, the MAC pass and the drain states, then the
// result is loaded; tap_count above TAPS counts as TAPS, and a tap_count of 0 skips
// the MAC pass. One sample at a time, through the single shared MAC pass over the delay
// and coefficient memories (one tap a cycle); a result still held on the output
// stalls the hand-off. Coefficient request: taken while idle. Output register holds a
// result while the next request is taken. Reset: phase zero, delay line reads as zero,
// no clearing pass; coefficients undefined until written.
// Top level; depends on qdf_pkg, qdf_ctrl, qdf_dp.
`timescale 1ns / 1ps

module quadrature_demodulator_fir
#(
    parameter int TAPS            = qdf_pkg::TAPS_DEF,
    parameter int SINE_TABLE_BITS = qdf_pkg::SINE_TABLE_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [5:0] coef_index, [21:6] coef_value, [37:22] sample, [39:38] zero
    input  logic [39:0]                    s_axis_tdata,
    // [0] kind
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [15:0] in_phase, [31:16] quadrature
    output logic [31:0]                    m_axis_tdata,
    input  logic                           cfg_we,
    input  logic [qdf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qdf_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [31:0]        phase_step_reg;
    logic [6:0]         tap_count_reg;
    qdf_pkg::cmd_t      cmd;
    qdf_pkg::status_t   status;
    logic signed [15:0] in_phase;
    logic signed [15:0] quadrature;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= qdf_pkg::PHASE_STEP_RST;
            tap_count_reg  <= qdf_pkg::TAP_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                qdf_pkg::REG_PHASE_STEP: phase_step_reg <= cfg_data[31:0];
                qdf_pkg::REG_TAP_COUNT:  tap_count_reg  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    qdf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .status   (status)
    );

    qdf_dp
    #(
        .TAPS            (TAPS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .phase_step (phase_step_reg),
        .tap_count  (tap_count_reg),
        .coef_index (s_axis_tdata[5:0]),
        .coef_value ($signed(s_axis_tdata[21:6])),
        .sample     ($signed(s_axis_tdata[37:22])),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .in_phase   (in_phase),
        .quadrature (quadrature)
    );

    assign m_axis_tdata = {quadrature, in_phase};

endmodule
